>>> hw/rtl/qr_data_segment_encoder_top_macros.svh
// Assertion macros for the data segment encoder.
`ifndef QR_DATA_SEGMENT_ENCODER_TOP_MACROS_SVH
`define QR_DATA_SEGMENT_ENCODER_TOP_MACROS_SVH

// Check a same-cycle implication.
`define QRDSE_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("qrdse assertion failed");

// Check an implication whose consequent holds in the next cycle.
`define QRDSE_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("qrdse assertion failed");

`endif

>>> hw/rtl/qrdse_pkg.sv
`default_nettype none

package qrdse_pkg;

    localparam int unsigned MAX_CAPACITY_BYTES = 4096;
    localparam int unsigned CAPB_W      = $clog2(MAX_CAPACITY_BYTES + 1);
    localparam int unsigned CAP_BITS_W  = CAPB_W + 3;
    localparam int unsigned LEVEL_W     = 16;
    localparam int unsigned CMP_W       =
        ((CAP_BITS_W > LEVEL_W) ? CAP_BITS_W : LEVEL_W) + 1;

    localparam int unsigned CHUNK_W     = 20;
    localparam int unsigned LEN_W       = 5;
    localparam int unsigned GROUP_W     = 11;
    localparam logic [LEN_W-1:0] MAX_CHUNK_LEN = 5'd20;

    localparam logic [1:0] CFG_MODE     = 2'd0;
    localparam logic [1:0] CFG_VERSION  = 2'd1;
    localparam logic [1:0] CFG_CAPACITY = 2'd2;
    localparam logic [1:0] CFG_MSG_LEN  = 2'd3;

    localparam logic [1:0] MODE_NUMERIC = 2'd0;
    localparam logic [1:0] MODE_ALNUM   = 2'd1;

    localparam logic [3:0] MI_NUMERIC   = 4'b0001;
    localparam logic [3:0] MI_ALNUM     = 4'b0010;
    localparam logic [3:0] MI_BYTE      = 4'b0100;

    localparam logic [7:0] PAD_BYTE_A   = 8'hEC;
    localparam logic [7:0] PAD_BYTE_B   = 8'h11;

    localparam logic [LEN_W-1:0] NUM_GROUP_LEN   = 5'd10;
    localparam logic [LEN_W-1:0] ALNUM_GROUP_LEN = 5'd11;
    localparam logic [LEN_W-1:0] ALNUM_FLUSH_LEN = 5'd6;
    localparam logic [LEN_W-1:0] BYTE_LEN        = 5'd8;

    typedef enum logic [1:0] {
        REQ_HEADER = 2'd0,
        REQ_CHAR   = 2'd1,
        REQ_FINISH = 2'd2,
        REQ_PAD    = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        PH_FIRST = 3'b001,
        PH_TERM  = 3'b010,
        PH_PAD   = 3'b100
    } phase_t;

    function automatic logic [4:0] count_width(input logic [1:0] mode,
                                               input logic [5:0] version);
        logic [1:0] row;
        logic [4:0] w;
        row = (version < 6'd10) ? 2'd0 : ((version < 6'd27) ? 2'd1 : 2'd2);
        case (mode)
            MODE_NUMERIC: w = 5'd10 + {2'b0, row, 1'b0};
            MODE_ALNUM:   w = 5'd9 + {2'b0, row, 1'b0};
            default:      w = (row == 2'd0) ? 5'd8 : 5'd16;
        endcase
        return w;
    endfunction

    function automatic logic [5:0] alnum_code(input logic [7:0] c);
        logic [5:0] v;
        case (c) inside
            [8'h30:8'h39]: v = 6'(c - 8'h30);
            [8'h41:8'h5A]: v = 6'(c - 8'h41 + 8'd10);
            8'h20:         v = 6'd36;
            8'h24:         v = 6'd37;
            8'h25:         v = 6'd38;
            8'h2A:         v = 6'd39;
            8'h2B:         v = 6'd40;
            8'h2D:         v = 6'd41;
            8'h2E:         v = 6'd42;
            8'h2F:         v = 6'd43;
            8'h3A:         v = 6'd44;
            default:       v = 6'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/qr_data_segment_encoder_top.sv
// Channel | Direction | Handshake          | Payload
// in      | sink      | in_valid/in_ready  | req_type, char_code
// out     | source    | out_valid/out_ready| chunk_value, chunk_len, overflow, done_res, last
// cfg     | sink      | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Header, character and pad requests give one chunk each: one a cycle when unstalled.
// Finish gives one to three chunks from its input register, one a cycle if unstalled.
// The result register sits between the input register and the out channel.
// cfg_ready is always high; writes are taken at any time.
// rst_n clears all control state and the configuration to its defaults.
`default_nettype none

`include "qr_data_segment_encoder_top_macros.svh"

module qr_data_segment_encoder_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  req_type,
    input  wire logic [7:0]  char_code,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [19:0]      chunk_value,
    output logic [4:0]       chunk_len,
    output logic             overflow,
    output logic             done_res,
    output logic             last,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int unsigned LW = qrdse_pkg::LEVEL_W;
    localparam int unsigned CW = qrdse_pkg::CMP_W;
    localparam int unsigned GW = qrdse_pkg::GROUP_W;
    localparam int unsigned NW = qrdse_pkg::LEN_W;
    localparam int unsigned VW = qrdse_pkg::CHUNK_W;

    logic [1:0]  mode_reg;
    logic [5:0]  version_reg;
    logic [11:0] capacity_reg;
    logic [15:0] msg_len_reg;

    logic [LW-1:0] bit_level_reg, bit_level_next;
    logic [GW-1:0] group_value_reg, group_value_next;
    logic [1:0]    group_count_reg, group_count_next;
    logic          pad_phase_reg, pad_phase_next;
    qrdse_pkg::phase_t phase_reg, phase_next;

    logic            item_valid_reg;
    qrdse_pkg::req_t req_reg;
    logic [7:0]      char_reg;

    logic          out_valid_reg;
    logic [VW-1:0] chunk_value_reg;
    logic [NW-1:0] chunk_len_reg;
    logic          overflow_reg;
    logic          done_res_reg;
    logic          last_reg;

    logic          fire;
    logic          item_done;
    logic [VW-1:0] res_value;
    logic [NW-1:0] res_len;
    logic          res_ovf;
    logic          res_done;
    logic          res_last;
    logic          level_clear;

    logic [qrdse_pkg::CAPB_W-1:0] cap_bytes;
    logic [CW-1:0]                cap_bits;
    logic [CW-1:0]                level_ext;
    logic [4:0]                   cnt_w;
    logic [3:0]                   mode_ind;
    logic [15:0]                  cnt_mask;
    logic [3:0]                   digit;
    logic [5:0]                   acode;
    logic                         have_flush;
    logic [NW-1:0]                flen;
    logic                         lvl_ovf;
    logic [CW-1:0]                room;
    logic [2:0]                   term;
    logic [2:0]                   term_end;
    logic [2:0]                   pad_len;
    logic [CW-1:0]                ceil_bytes;
    logic [LW:0]                  level_sum;
    logic [LW-1:0]                level_base;

    assign cfg_ready = 1'b1;
    assign fire      = item_valid_reg && (!out_valid_reg || out_ready);
    assign item_done = fire && res_last;
    assign in_ready  = !item_valid_reg || item_done;

    assign cap_bytes = (capacity_reg > 12'(qrdse_pkg::MAX_CAPACITY_BYTES - 1))
                       ? qrdse_pkg::CAPB_W'(qrdse_pkg::MAX_CAPACITY_BYTES)
                       : qrdse_pkg::CAPB_W'(capacity_reg);
    assign cap_bits  = CW'({cap_bytes, 3'b000});
    assign level_ext = CW'(bit_level_reg);

    assign cnt_w    = qrdse_pkg::count_width(mode_reg, version_reg);
    assign cnt_mask = 16'((17'd1 << cnt_w) - 17'd1);
    assign mode_ind = (mode_reg == qrdse_pkg::MODE_NUMERIC) ? qrdse_pkg::MI_NUMERIC :
                      (mode_reg == qrdse_pkg::MODE_ALNUM)   ? qrdse_pkg::MI_ALNUM :
                                                              qrdse_pkg::MI_BYTE;
    assign digit = (char_reg >= 8'h30 && char_reg <= 8'h39) ? 4'(char_reg - 8'h30) : 4'd0;
    assign acode = qrdse_pkg::alnum_code(char_reg);

    assign have_flush = (group_count_reg != 2'd0) &&
                        (mode_reg == qrdse_pkg::MODE_NUMERIC ||
                         mode_reg == qrdse_pkg::MODE_ALNUM);
    assign flen = (mode_reg == qrdse_pkg::MODE_NUMERIC)
                  ? NW'({group_count_reg, 1'b0} + {1'b0, group_count_reg} + 3'd1)
                  : qrdse_pkg::ALNUM_FLUSH_LEN;
    assign lvl_ovf  = level_ext > cap_bits;
    assign room     = cap_bits - level_ext;
    assign term     = lvl_ovf ? 3'd0 : ((room > CW'(4)) ? 3'd4 : room[2:0]);
    assign term_end = bit_level_reg[2:0] + term;
    assign pad_len  = 3'd0 - bit_level_reg[2:0];
    assign ceil_bytes = CW'((level_ext + CW'(7)) >> 3);

    always_comb
    begin
        res_value        = '0;
        res_len          = '0;
        res_ovf          = 1'b0;
        res_done         = 1'b0;
        res_last         = 1'b1;
        level_clear      = 1'b0;
        group_value_next = group_value_reg;
        group_count_next = group_count_reg;
        pad_phase_next   = pad_phase_reg;
        phase_next       = qrdse_pkg::PH_FIRST;
        case (req_reg)
            qrdse_pkg::REQ_HEADER:
            begin
                level_clear      = 1'b1;
                group_value_next = '0;
                group_count_next = '0;
                pad_phase_next   = 1'b0;
                res_value = (VW'(mode_ind) << cnt_w) | VW'(msg_len_reg & cnt_mask);
                res_len   = NW'(cnt_w + 5'd4);
            end
            qrdse_pkg::REQ_CHAR:
            begin
                if (mode_reg == qrdse_pkg::MODE_NUMERIC)
                begin
                    group_value_next = group_value_reg * GW'(10) + GW'(digit);
                    if (group_count_reg >= 2'd2)
                    begin
                        res_value        = VW'(group_value_next);
                        res_len          = qrdse_pkg::NUM_GROUP_LEN;
                        group_value_next = '0;
                        group_count_next = '0;
                    end
                    else
                    begin
                        group_count_next = group_count_reg + 2'd1;
                    end
                end
                else if (mode_reg == qrdse_pkg::MODE_ALNUM)
                begin
                    group_value_next = group_value_reg * GW'(45) + GW'(acode);
                    if (group_count_reg >= 2'd1)
                    begin
                        res_value        = VW'(group_value_next);
                        res_len          = qrdse_pkg::ALNUM_GROUP_LEN;
                        group_value_next = '0;
                        group_count_next = '0;
                    end
                    else
                    begin
                        group_count_next = 2'd1;
                    end
                end
                else
                begin
                    res_value = VW'(char_reg);
                    res_len   = qrdse_pkg::BYTE_LEN;
                end
            end
            qrdse_pkg::REQ_FINISH:
            begin
                group_value_next = '0;
                group_count_next = '0;
                if (phase_reg == qrdse_pkg::PH_FIRST && have_flush)
                begin
                    res_value  = VW'(group_value_reg);
                    res_len    = flen;
                    res_ovf    = (level_ext + CW'(flen)) > cap_bits;
                    res_last   = 1'b0;
                    phase_next = qrdse_pkg::PH_TERM;
                end
                else if (phase_reg == qrdse_pkg::PH_PAD)
                begin
                    res_len = NW'(pad_len);
                    res_ovf = lvl_ovf;
                end
                else
                begin
                    res_len    = NW'(term);
                    res_ovf    = lvl_ovf;
                    res_last   = (term_end == 3'd0);
                    phase_next = res_last ? qrdse_pkg::PH_FIRST : qrdse_pkg::PH_PAD;
                end
            end
            default:
            begin
                if (ceil_bytes < CW'(cap_bytes))
                begin
                    res_value      = VW'(pad_phase_reg ? qrdse_pkg::PAD_BYTE_B
                                                       : qrdse_pkg::PAD_BYTE_A);
                    res_len        = qrdse_pkg::BYTE_LEN;
                    pad_phase_next = !pad_phase_reg;
                end
                else
                begin
                    res_done = 1'b1;
                end
            end
        endcase
    end

    assign level_base     = level_clear ? '0 : bit_level_reg;
    assign level_sum      = {1'b0, level_base} + (LW + 1)'(res_len);
    assign bit_level_next = level_sum[LW] ? '1 : level_sum[LW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= '0;
            version_reg  <= 6'd1;
            capacity_reg <= 12'd19;
            msg_len_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                qrdse_pkg::CFG_MODE:     mode_reg     <= cfg_data[1:0];
                qrdse_pkg::CFG_VERSION:  version_reg  <= cfg_data[5:0];
                qrdse_pkg::CFG_CAPACITY: capacity_reg <= cfg_data[11:0];
                qrdse_pkg::CFG_MSG_LEN:  msg_len_reg  <= cfg_data;
                default:                 mode_reg     <= mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_level_reg   <= '0;
            group_value_reg <= '0;
            group_count_reg <= '0;
            pad_phase_reg   <= 1'b0;
            phase_reg       <= qrdse_pkg::PH_FIRST;
            item_valid_reg  <= 1'b0;
            req_reg         <= qrdse_pkg::REQ_HEADER;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                bit_level_reg   <= bit_level_next;
                group_value_reg <= group_value_next;
                group_count_reg <= group_count_next;
                pad_phase_reg   <= pad_phase_next;
                phase_reg       <= phase_next;
            end
            if (in_valid && in_ready)
            begin
                item_valid_reg <= 1'b1;
                req_reg        <= qrdse_pkg::req_t'(req_type);
            end
            else if (item_done)
            begin
                item_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            char_reg <= char_code;
        end
        if (fire)
        begin
            chunk_value_reg <= res_value & VW'((21'd1 << res_len) - 21'd1);
            chunk_len_reg   <= res_len;
            overflow_reg    <= res_ovf;
            done_res_reg    <= res_done;
            last_reg        <= res_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign chunk_value = chunk_value_reg;
    assign chunk_len   = chunk_len_reg;
    assign overflow    = overflow_reg;
    assign done_res    = done_res_reg;
    assign last        = last_reg;

    `QRDSE_ASSERT_NOW(a_len_range, clk, rst_n, out_valid, chunk_len <= qrdse_pkg::MAX_CHUNK_LEN)
    `QRDSE_ASSERT_NOW(a_value_masked, clk, rst_n, out_valid, (chunk_value >> chunk_len) == 20'd0)
    `QRDSE_ASSERT_NOW(a_done_empty, clk, rst_n, out_valid && done_res, chunk_len == 5'd0 && last)
    `QRDSE_ASSERT_NOW(a_phase_finish, clk, rst_n, item_valid_reg && phase_reg != qrdse_pkg::PH_FIRST, req_reg == qrdse_pkg::REQ_FINISH)
    `QRDSE_ASSERT_NEXT(a_hold_item, clk, rst_n, item_valid_reg && !item_done, item_valid_reg && $stable(req_reg))

endmodule

`default_nettype wire

>>> tb/qr_data_segment_encoder_top_test.sv
`timescale 1ns / 100ps

module qr_data_segment_encoder_top_test;

    localparam logic [1:0] MODE_BYTE   = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned MAX_REPORTS  = 10;

    typedef struct packed {
        logic [19:0] value;
        logic [4:0]  len;
        logic        ovf;
        logic        done;
        logic        last;
    } chunk_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  req_type;
    logic [7:0]  char_code;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [19:0] chunk_value;
    logic [4:0]  chunk_len;
    logic        overflow;
    logic        done_res;
    logic        last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    // encoder image kept alongside the block
    logic [1:0]  cfg_mode;
    logic [5:0]  cfg_version;
    logic [11:0] cfg_capacity;
    logic [15:0] cfg_msg_len;
    logic [15:0] level;
    logic [10:0] grp_value;
    logic [1:0]  grp_count;
    logic        pad_odd;

    chunk_t      expected_chunks[$];
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    int unsigned request_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    string       alnum_set = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ $%*+-./:";

    qr_data_segment_encoder_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .char_code   (char_code),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .chunk_value (chunk_value),
        .chunk_len   (chunk_len),
        .overflow    (overflow),
        .done_res    (done_res),
        .last        (last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int unsigned indicator_width();
        int unsigned row;
        row = (cfg_version < 10) ? 0 : ((cfg_version < 27) ? 1 : 2);
        if (cfg_mode == qrdse_pkg::MODE_NUMERIC)
            return 10 + 2 * row;
        if (cfg_mode == qrdse_pkg::MODE_ALNUM)
            return 9 + 2 * row;
        return (row == 0) ? 8 : 16;
    endfunction

    function automatic int unsigned alnum_value(logic [7:0] c);
        if (c >= "0" && c <= "9")
            return c - "0";
        if (c >= "A" && c <= "Z")
            return c - "A" + 10;
        case (c)
            " ":     return 36;
            "$":     return 37;
            "%":     return 38;
            "*":     return 39;
            "+":     return 40;
            "-":     return 41;
            ".":     return 42;
            "/":     return 43;
            ":":     return 44;
            default: return 0;
        endcase
    endfunction

    function automatic int unsigned capacity_bits();
        int unsigned c;
        c = cfg_capacity;
        if (c > qrdse_pkg::MAX_CAPACITY_BYTES)
            c = qrdse_pkg::MAX_CAPACITY_BYTES;
        return c * 8;
    endfunction

    function automatic void push_chunk(int unsigned val, int unsigned len,
                                       logic ovf, logic done, logic fin);
        chunk_t      ch;
        int unsigned t;
        ch.value = 20'(val & ((1 << len) - 1));
        ch.len   = 5'(len);
        ch.ovf   = ovf;
        ch.done  = done;
        ch.last  = fin;
        expected_chunks.push_back(ch);
        t = level + len;
        level = (t > 16'hFFFF) ? 16'hFFFF : t[15:0];
    endfunction

    function automatic void predict_chunks(qrdse_pkg::req_t kind, logic [7:0] code);
        int unsigned w, mi, d, fval, flen, cap, term, pad;
        logic        ovf, have_flush;
        case (kind)
            qrdse_pkg::REQ_HEADER:
            begin
                w  = indicator_width();
                mi = (cfg_mode == qrdse_pkg::MODE_NUMERIC) ? qrdse_pkg::MI_NUMERIC :
                     ((cfg_mode == qrdse_pkg::MODE_ALNUM) ? qrdse_pkg::MI_ALNUM
                                                          : qrdse_pkg::MI_BYTE);
                level     = '0;
                grp_value = '0;
                grp_count = '0;
                pad_odd   = 1'b0;
                push_chunk((mi << w) | (cfg_msg_len & ((1 << w) - 1)), 4 + w,
                           1'b0, 1'b0, 1'b1);
            end
            qrdse_pkg::REQ_CHAR:
            begin
                if (cfg_mode == qrdse_pkg::MODE_NUMERIC)
                begin
                    d = (code >= "0" && code <= "9") ? code - "0" : 0;
                    grp_value = 11'(grp_value * 10 + d);
                    if (grp_count >= 2)
                    begin
                        push_chunk(grp_value, qrdse_pkg::NUM_GROUP_LEN, 1'b0, 1'b0, 1'b1);
                        grp_value = '0;
                        grp_count = '0;
                    end
                    else
                    begin
                        grp_count++;
                        push_chunk(0, 0, 1'b0, 1'b0, 1'b1);
                    end
                end
                else if (cfg_mode == qrdse_pkg::MODE_ALNUM)
                begin
                    grp_value = 11'(grp_value * 45 + alnum_value(code));
                    if (grp_count >= 1)
                    begin
                        push_chunk(grp_value, qrdse_pkg::ALNUM_GROUP_LEN, 1'b0, 1'b0, 1'b1);
                        grp_value = '0;
                        grp_count = '0;
                    end
                    else
                    begin
                        grp_count = 2'd1;
                        push_chunk(0, 0, 1'b0, 1'b0, 1'b1);
                    end
                end
                else
                    push_chunk(code, qrdse_pkg::BYTE_LEN, 1'b0, 1'b0, 1'b1);
            end
            qrdse_pkg::REQ_FINISH:
            begin
                have_flush = 1'b0;
                fval = 0;
                flen = 0;
                if (grp_count > 0 && cfg_mode == qrdse_pkg::MODE_NUMERIC)
                begin
                    have_flush = 1'b1;
                    fval = grp_value;
                    flen = grp_count * 3 + 1;
                end
                else if (grp_count > 0 && cfg_mode == qrdse_pkg::MODE_ALNUM)
                begin
                    have_flush = 1'b1;
                    fval = grp_value;
                    flen = qrdse_pkg::ALNUM_FLUSH_LEN;
                end
                grp_value = '0;
                grp_count = '0;
                cap = capacity_bits();
                ovf = (level + flen > cap);
                if (have_flush)
                    push_chunk(fval, flen, ovf, 1'b0, 1'b0);
                if (ovf)
                    term = 0;
                else
                begin
                    term = cap - level;
                    if (term > 4)
                        term = 4;
                end
                pad = (8 - ((level + term) & 7)) & 7;
                push_chunk(0, term, ovf, 1'b0, pad == 0);
                if (pad != 0)
                    push_chunk(0, pad, ovf, 1'b0, 1'b1);
            end
            default:
            begin
                if ((level + 7) / 8 < capacity_bits() / 8)
                begin
                    push_chunk(pad_odd ? qrdse_pkg::PAD_BYTE_B : qrdse_pkg::PAD_BYTE_A, 8,
                               1'b0, 1'b0, 1'b1);
                    pad_odd = ~pad_odd;
                end
                else
                    push_chunk(0, 0, 1'b0, 1'b1, 1'b1);
            end
        endcase
    endfunction

    always @(posedge clk)
    begin : check_chunks
        chunk_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_chunks.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected chunk: value=%h len=%0d ovf=%b done=%b last=%b",
                             chunk_value, chunk_len, overflow, done_res, last);
            end
            else
            begin
                want = expected_chunks.pop_front();
                if (want.value !== chunk_value || want.len !== chunk_len ||
                    want.ovf !== overflow || want.done !== done_res ||
                    want.last !== last)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("chunk mismatch: expected value=%h len=%0d ovf=%b done=%b",
                                 want.value, want.len, want.ovf, want.done,
                                 " last=%b, got value=%h len=%0d ovf=%b done=%b last=%b",
                                 want.last, chunk_value, chunk_len, overflow, done_res,
                                 last);
                end
            end
        end
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_request(qrdse_pkg::req_t kind, logic [7:0] code);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid  <= 1'b1;
        req_type  <= kind;
        char_code <= code;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_chunks(kind, code);
        request_count++;
    endtask

    // drop valid and hold until every expected chunk has arrived
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_chunks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_config(logic [1:0] m, logic [5:0] ver, logic [11:0] cap,
                                logic [15:0] len);
        logic [1:0]  idx[4];
        logic [15:0] vals[4];
        idx  = '{qrdse_pkg::CFG_MODE, qrdse_pkg::CFG_VERSION, qrdse_pkg::CFG_CAPACITY,
                 qrdse_pkg::CFG_MSG_LEN};
        vals = '{{14'd0, m}, {10'd0, ver}, {4'd0, cap}, len};
        drain();
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            case (idx[i])
                qrdse_pkg::CFG_MODE:     cfg_mode     = vals[i][1:0];
                qrdse_pkg::CFG_VERSION:  cfg_version  = vals[i][5:0];
                qrdse_pkg::CFG_CAPACITY: cfg_capacity = vals[i][11:0];
                default:                 cfg_msg_len  = vals[i];
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_request(qrdse_pkg::REQ_CHAR, s[i]);
    endtask

    function automatic logic [7:0] pick_char(logic [1:0] m);
        if ($urandom_range(9) == 0 || m == MODE_BYTE || m == MODE_UNUSED)
            return 8'($urandom_range(255));
        if (m == qrdse_pkg::MODE_NUMERIC)
            return 8'("0" + $urandom_range(9));
        return alnum_set[$urandom_range(44)];
    endfunction

    task automatic pick_random_config();
        logic [5:0]  corner_versions[8];
        logic [5:0]  ver;
        logic [11:0] cap;
        int unsigned sel;
        corner_versions = '{6'd0, 6'd1, 6'd9, 6'd10, 6'd26, 6'd27, 6'd40, 6'd63};
        ver = ($urandom_range(2) == 0) ? corner_versions[$urandom_range(7)]
                                       : 6'($urandom_range(63));
        sel = $urandom_range(9);
        cap = (sel == 0) ? 12'd1 : ((sel == 1) ? 12'd4095 : 12'($urandom_range(24, 1)));
        write_config(2'($urandom_range(3)), ver, cap, 16'($urandom_range(65535)));
    endtask

    task automatic test_numeric_groups();
        write_config(qrdse_pkg::MODE_NUMERIC, 6'd1, 12'd5, 16'hFFFF);
        send_request(qrdse_pkg::REQ_HEADER, 8'h00);
        send_text("099");
        send_request(qrdse_pkg::REQ_CHAR, "9");
        send_request(qrdse_pkg::REQ_CHAR, 8'hFF);
        send_request(qrdse_pkg::REQ_CHAR, 8'h00);
        send_request(qrdse_pkg::REQ_CHAR, "5");
        send_request(qrdse_pkg::REQ_FINISH, 8'h00);
        send_request(qrdse_pkg::REQ_PAD, 8'h00);
    endtask

    task automatic test_alnum_padding();
        write_config(qrdse_pkg::MODE_ALNUM, 6'd40, 12'd19, 16'd5);
        send_request(qrdse_pkg::REQ_HEADER, 8'h00);
        send_text("AZ:");
        send_request(qrdse_pkg::REQ_FINISH, 8'h00);
        send_request(qrdse_pkg::REQ_PAD, 8'h00);
        send_request(qrdse_pkg::REQ_PAD, 8'h00);
    endtask

    task automatic test_byte_overflow();
        write_config(MODE_BYTE, 6'd26, 12'd1, 16'hABCD);
        send_request(qrdse_pkg::REQ_HEADER, 8'h00);
        send_request(qrdse_pkg::REQ_CHAR, 8'hFF);
        send_request(qrdse_pkg::REQ_CHAR, 8'h00);
        send_request(qrdse_pkg::REQ_FINISH, 8'h00);
        send_request(qrdse_pkg::REQ_PAD, 8'h00);
    endtask

    task automatic test_mode_switch();
        write_config(qrdse_pkg::MODE_NUMERIC, 6'd0, 12'd4095, 16'd0);
        send_request(qrdse_pkg::REQ_HEADER, 8'h00);
        send_text("12");
        write_config(qrdse_pkg::MODE_ALNUM, 6'd0, 12'd4095, 16'd0);
        send_text("BC");
        write_config(MODE_UNUSED, 6'd63, 12'd4095, 16'd0);
        send_request(qrdse_pkg::REQ_FINISH, 8'h00);
        send_request(qrdse_pkg::REQ_HEADER, 8'h00);
        send_request(qrdse_pkg::REQ_PAD, 8'h00);
    endtask

    task automatic test_exact_fill();
        write_config(MODE_BYTE, 6'd1, 12'd4, 16'd2);
        send_request(qrdse_pkg::REQ_HEADER, 8'h00);
        send_request(qrdse_pkg::REQ_CHAR, 8'h5A);
        send_request(qrdse_pkg::REQ_CHAR, 8'hA5);
        send_request(qrdse_pkg::REQ_FINISH, 8'h00);
        send_request(qrdse_pkg::REQ_PAD, 8'h00);
        send_request(qrdse_pkg::REQ_PAD, 8'h00);
    endtask

    task automatic test_random_traffic(int unsigned n, int unsigned idle_pct,
                                       int unsigned stall_pct);
        int unsigned first;
        drain();
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        first = request_count;
        while (request_count - first < n)
        begin
            pick_random_config();
            if ($urandom_range(99) < 15)
            begin
                repeat ($urandom_range(6, 1))
                    send_request(qrdse_pkg::req_t'($urandom_range(3)),
                                 8'($urandom_range(255)));
            end
            else
            begin
                send_request(qrdse_pkg::REQ_HEADER, 8'($urandom_range(255)));
                repeat ($urandom_range(12))
                begin
                    if ($urandom_range(99) < 5)
                        write_config(2'($urandom_range(3)), cfg_version, cfg_capacity,
                                     cfg_msg_len);
                    send_request(qrdse_pkg::REQ_CHAR, pick_char(cfg_mode));
                end
                if ($urandom_range(9) != 0)
                    send_request(qrdse_pkg::REQ_FINISH, 8'($urandom_range(255)));
                repeat ($urandom_range(4))
                    send_request(qrdse_pkg::REQ_PAD, 8'($urandom_range(255)));
            end
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        req_type  <= qrdse_pkg::REQ_HEADER;
        char_code <= 8'h00;
        cfg_valid <= 1'b0;
        cfg_index <= qrdse_pkg::CFG_MODE;
        cfg_data  <= 16'h0000;
        cfg_mode     = qrdse_pkg::MODE_NUMERIC;
        cfg_version  = 6'd1;
        cfg_capacity = 12'd19;
        cfg_msg_len  = 16'd0;
        level     = '0;
        grp_value = '0;
        grp_count = '0;
        pad_odd   = 1'b0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_numeric_groups();
        test_alnum_padding();
        test_byte_overflow();
        test_mode_switch();
        test_exact_fill();
        test_random_traffic(35, 0, 0);
        test_random_traffic(35, 61, 0);
        test_random_traffic(35, 0, 61);
        test_random_traffic(35, 28, 28);

        drain();
        repeat (10)
            @(posedge clk);
        if (fail_count == 0 && expected_chunks.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
